// ===== src/qpe_pkg.sv =====
package qpe_pkg;

	localparam int LINE_LIMIT = 72;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int NSLOT = 15;
	localparam int SLOT_W = $clog2(NSLOT);

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_DEL = 8'h7F;

	localparam logic [1:0] REG_ESCAPE_FROM = 2'd0;
	localparam logic [1:0] REG_DOT_STUFFING = 2'd1;
	localparam logic [1:0] REG_EOL_CRLF = 2'd2;

	// output slots, emitted lowest first
	localparam logic [SLOT_W-1:0] SLOT_A0 = 4'd0;
	localparam logic [SLOT_W-1:0] SLOT_A1 = 4'd1;
	localparam logic [SLOT_W-1:0] SLOT_A2 = 4'd2;
	localparam logic [SLOT_W-1:0] SLOT_B0 = 4'd3;
	localparam logic [SLOT_W-1:0] SLOT_B1 = 4'd4;
	localparam logic [SLOT_W-1:0] SLOT_B2 = 4'd5;
	localparam logic [SLOT_W-1:0] SLOT_DOT = 4'd6;
	localparam logic [SLOT_W-1:0] SLOT_D0 = 4'd7;
	localparam logic [SLOT_W-1:0] SLOT_D1 = 4'd8;
	localparam logic [SLOT_W-1:0] SLOT_D2 = 4'd9;
	localparam logic [SLOT_W-1:0] SLOT_F0 = 4'd10;
	localparam logic [SLOT_W-1:0] SLOT_F1 = 4'd11;
	localparam logic [SLOT_W-1:0] SLOT_F2 = 4'd12;
	localparam logic [SLOT_W-1:0] SLOT_F3 = 4'd13;
	localparam logic [SLOT_W-1:0] SLOT_F4 = 4'd14;

	typedef struct packed {
		logic [NSLOT-1:0] mask;
		logic [7:0]       a_byte;
		logic [7:0]       c_byte;
		logic             a_hex;
		logic             d_hex;
	} desc_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		hex_digit = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
	endfunction

	function automatic logic [7:0] from_char(input logic [1:0] i);
		case (i)
			2'd0: from_char = 8'h46;
			2'd1: from_char = 8'h72;
			2'd2: from_char = 8'h6F;
			default: from_char = 8'h6D;
		endcase
	endfunction

endpackage

// ===== src/quoted_printable_stream_encoder.sv =====
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    tdata: data_byte; tuser: has_byte; tlast: end_of_part
// m_       out  m_tvalid/m_tready    tdata: out_byte; tlast: last
// cfg_     in   cfg_valid/cfg_ready  cfg_index: 0 escape_from, 1 dot_stuffing, 2 eol_crlf
//
// Front takes one item per cycle into a four-entry queue while it is not full; the back
// end emits one encoded byte per cycle while m_tready allows, and an item yields up to
// nine bytes (1 to 3 typically); an item yielding nothing is not queued.
// Reset: escape_from 0, dot_stuffing 0, eol_crlf 1, fresh line, queue empty.
// m_tready low holds the output register; s_tready drops only when the queue is full.
module quoted_printable_stream_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic       s_tuser,  // [0] has_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic       m_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data
);
	import qpe_pkg::*;

	logic  accept, push, pop, full, head_valid;
	desc_t desc, head;

	assign s_tready = !full;
	assign cfg_ready = 1'b1;
	assign accept = s_tvalid && s_tready;

	qpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.has_byte   (s_tuser),
		.data_byte  (s_tdata),
		.end_of_part(s_tlast),
		.push       (push),
		.desc       (desc)
	);

	qpe_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (desc),
		.pop   (pop),
		.full  (full),
		.valid (head_valid),
		.dout  (head)
	);

	qpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== src/qpe_front.sv =====
module qpe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [1:0]        cfg_index,
	input  logic              cfg_data,
	input  logic              accept,
	input  logic              has_byte,
	input  logic [7:0]        data_byte,
	input  logic              end_of_part,
	output logic              push,
	output qpe_pkg::desc_t    desc
);
	import qpe_pkg::*;

	logic       escape_from_q, dot_stuffing_q, eol_crlf_q;
	logic [7:0] held_q;
	logic [6:0] len_q;
	logic [2:0] fm_q;

	logic [7:0] h_n, l_a, l_b, l_c, l_n, l_f;
	logic [2:0] fm_n;
	logic       hb_lf, a_hex, a_lit, soft_brk, dot, d_hex, d_lit, lf_in, f_hex, f_eol;
	logic       blank_h, blank_c, esc_c, from_case;
	logic [NSLOT-1:0] mask;

	always_comb begin
		blank_h = (held_q == CH_SP) || (held_q == CH_TAB);
		blank_c = (data_byte == CH_SP) || (data_byte == CH_TAB);
		esc_c = (data_byte < CH_SP && data_byte != CH_TAB) || data_byte >= CH_DEL
			|| data_byte == CH_EQ;
		lf_in = has_byte && data_byte == CH_LF;
		from_case = held_q == CH_SP && len_q == 7'd4 && fm_q == 3'd4 && escape_from_q;
		a_hex = 1'b0;
		a_lit = 1'b0;
		soft_brk = 1'b0;
		dot = 1'b0;
		d_hex = 1'b0;
		d_lit = 1'b0;
		h_n = held_q;
		fm_n = fm_q;
		l_a = {1'b0, len_q};
		l_b = l_a;
		l_c = l_a;
		l_n = l_a;
		hb_lf = 1'b0;
		if (lf_in) begin
			a_hex = blank_h;
			l_n = 8'd0;
			fm_n = 3'd0;
			h_n = data_byte;
		end else if (has_byte) begin
			if (from_case) begin
				a_hex = 1'b1;
				l_a = {1'b0, len_q} + 8'd3;
			end else if (blank_h) begin
				a_lit = 1'b1;
				l_a = {1'b0, len_q} + 8'd1;
			end
			l_b = l_a;
			hb_lf = held_q == CH_LF;
			if (l_a > 8'(LINE_LIMIT)) begin
				soft_brk = 1'b1;
				l_b = 8'd0;
				fm_n = 3'd0;
				hb_lf = 1'b1;
			end
			dot = hb_lf && data_byte == CH_DOT && dot_stuffing_q;
			l_c = l_b + {7'd0, dot};
			l_n = l_c;
			if (esc_c) begin
				d_hex = 1'b1;
				l_n = l_c + 8'd3;
			end else if (!blank_c) begin
				d_lit = 1'b1;
				if (l_c < 8'd4 && data_byte == from_char(l_c[1:0]))
					fm_n = fm_n + 3'd1;
				l_n = l_c + 8'd1;
			end
			h_n = data_byte;
		end
		f_hex = end_of_part && ((h_n == CH_SP) || (h_n == CH_TAB));
		l_f = l_n + (f_hex ? 8'd3 : 8'd0);
		f_eol = end_of_part && l_f != 8'd0;

		mask = '0;
		mask[SLOT_A0] = a_hex || a_lit;
		mask[SLOT_A1] = a_hex;
		mask[SLOT_A2] = a_hex;
		mask[SLOT_B0] = soft_brk;
		mask[SLOT_B1] = (soft_brk || lf_in) && eol_crlf_q;
		mask[SLOT_B2] = soft_brk || lf_in;
		mask[SLOT_DOT] = dot;
		mask[SLOT_D0] = d_hex || d_lit;
		mask[SLOT_D1] = d_hex;
		mask[SLOT_D2] = d_hex;
		mask[SLOT_F0] = f_hex;
		mask[SLOT_F1] = f_hex;
		mask[SLOT_F2] = f_hex;
		mask[SLOT_F3] = f_eol && eol_crlf_q;
		mask[SLOT_F4] = f_eol;

		desc.mask = mask;
		desc.a_byte = held_q;
		desc.c_byte = h_n;
		desc.a_hex = a_hex;
		desc.d_hex = d_hex;
		push = accept && (mask != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_from_q <= 1'b0;
			dot_stuffing_q <= 1'b0;
			eol_crlf_q <= 1'b1;
			held_q <= CH_LF;
			len_q <= '0;
			fm_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_ESCAPE_FROM: escape_from_q <= cfg_data;
					REG_DOT_STUFFING: dot_stuffing_q <= cfg_data;
					REG_EOL_CRLF: eol_crlf_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				if (end_of_part) begin
					held_q <= CH_LF;
					len_q <= '0;
					fm_q <= '0;
				end else begin
					held_q <= h_n;
					len_q <= l_n[6:0];
					fm_q <= fm_n;
				end
			end
		end
	end

endmodule

// ===== src/qpe_queue.sv =====
module qpe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  qpe_pkg::desc_t din,
	input  logic           pop,
	output logic           full,
	output logic           valid,
	output qpe_pkg::desc_t dout
);
	import qpe_pkg::*;

	desc_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign valid = cnt_q != '0;
	assign dout = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== src/qpe_back.sv =====
module qpe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  qpe_pkg::desc_t head,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,
	output logic           m_tlast
);
	import qpe_pkg::*;

	logic [NSLOT-1:0] done_q, rem, sel_bit, rem_after;
	logic [SLOT_W-1:0] slot;
	logic [7:0]        byte_n;
	logic              found, advance, emit, fin;
	logic              out_valid_q, out_last_q;
	logic [7:0]        out_byte_q;

	always_comb begin
		rem = head.mask & ~done_q;
		slot = '0;
		found = 1'b0;
		for (int i = 0; i < NSLOT; i++) begin
			if (!found && rem[i]) begin
				slot = SLOT_W'(i);
				found = 1'b1;
			end
		end
		sel_bit = NSLOT'(1) << slot;
		rem_after = rem & ~sel_bit;
		fin = rem_after == '0;
		case (slot)
			SLOT_A0: byte_n = head.a_hex ? CH_EQ : head.a_byte;
			SLOT_A1: byte_n = hex_digit(head.a_byte[7:4]);
			SLOT_A2: byte_n = hex_digit(head.a_byte[3:0]);
			SLOT_B0: byte_n = CH_EQ;
			SLOT_B1: byte_n = CH_CR;
			SLOT_B2: byte_n = CH_LF;
			SLOT_DOT: byte_n = CH_DOT;
			SLOT_D0: byte_n = head.d_hex ? CH_EQ : head.c_byte;
			SLOT_D1: byte_n = hex_digit(head.c_byte[7:4]);
			SLOT_D2: byte_n = hex_digit(head.c_byte[3:0]);
			SLOT_F0: byte_n = CH_EQ;
			SLOT_F1: byte_n = hex_digit(head.c_byte[7:4]);
			SLOT_F2: byte_n = hex_digit(head.c_byte[3:0]);
			SLOT_F3: byte_n = CH_CR;
			default: byte_n = CH_LF;
		endcase
		advance = !out_valid_q || m_tready;
		emit = head_valid && advance;
		pop = emit && fin;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_byte_q;
	assign m_tlast = out_last_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_n;
			out_last_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q <= '0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			if (emit)
				done_q <= fin ? '0 : (done_q | sel_bit);
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import qpe_pkg::*;

	localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";
	localparam logic [31:0]  FROM_WORD  = "From";
	localparam int           STALL_LIMIT = 5000;
	localparam int           SETTLE_CYCLES = 64;

	typedef struct {
		logic [7:0] b;
		bit         last;
	} coded_t;

	// encoder state and registers, expected output bytes in order
	class qp_encoded_bytes;
		bit         esc_from;
		bit         dot_stuff;
		bit         crlf;
		logic [7:0] held;
		int         line_len;
		int         from_cnt;
		coded_t     coded_q[$];
		int         bad_count;

		function new();
			esc_from = 1'b0;
			dot_stuff = 1'b0;
			crlf = 1'b1;
			held = CH_LF;
			line_len = 0;
			from_cnt = 0;
			bad_count = 0;
		endfunction

		function void set_reg(logic [1:0] idx, bit v);
			case (idx)
				REG_ESCAPE_FROM: esc_from = v;
				REG_DOT_STUFFING: dot_stuff = v;
				REG_EOL_CRLF: crlf = v;
				default: ;
			endcase
		endfunction

		function int pending();
			return coded_q.size();
		endfunction

		function void put_byte(logic [7:0] b);
			coded_t e;
			e.b = b;
			e.last = 1'b0;
			coded_q.push_back(e);
		endfunction

		function void put_hex(logic [7:0] c);
			put_byte(CH_EQ);
			put_byte(HEX_DIGITS[8*(15-c[7:4]) +: 8]);
			put_byte(HEX_DIGITS[8*(15-c[3:0]) +: 8]);
		endfunction

		function void put_eol();
			if (crlf)
				put_byte(CH_CR);
			put_byte(CH_LF);
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == CH_SP || c == CH_TAB;
		endfunction

		function void encode(logic [7:0] c);
			if (c == CH_LF) begin
				if (is_blank(held))
					put_hex(held);
				put_eol();
				line_len = 0;
				from_cnt = 0;
				held = c;
				return;
			end
			if (held == CH_SP && line_len == 4 && from_cnt == 4 && esc_from) begin
				put_hex(CH_SP);
				line_len += 3;
			end else if (is_blank(held)) begin
				put_byte(held);
				line_len++;
			end
			// soft break
			if (line_len > LINE_LIMIT) begin
				put_byte(CH_EQ);
				put_eol();
				line_len = 0;
				from_cnt = 0;
				held = CH_LF;
			end
			if (held == CH_LF && c == CH_DOT && dot_stuff) begin
				put_byte(CH_DOT);
				line_len++;
			end
			if ((c < CH_SP && c != CH_TAB) || c >= CH_DEL || c == CH_EQ) begin
				put_hex(c);
				line_len += 3;
			end else if (!is_blank(c)) begin
				if (line_len < 4 && c == FROM_WORD[8*(3-line_len) +: 8])
					from_cnt++;
				put_byte(c);
				line_len++;
			end
			held = c;
		endfunction

		function void flush_part();
			if (is_blank(held)) begin
				put_hex(held);
				line_len += 3;
			end
			if (line_len > 0)
				put_eol();
			held = CH_LF;
			line_len = 0;
			from_cnt = 0;
		endfunction

		function void take_raw(bit hb, logic [7:0] d, bit eop);
			int     n0;
			coded_t e;
			n0 = coded_q.size();
			if (hb)
				encode(d);
			if (eop)
				flush_part();
			line_len &= 32'h7F;
			from_cnt &= 32'h7;
			if (coded_q.size() > n0) begin
				e = coded_q.pop_back();
				e.last = 1'b1;
				coded_q.push_back(e);
			end
		endfunction

		function void match_byte(logic [7:0] b, logic last);
			coded_t e;
			if (coded_q.size() == 0) begin
				$display("%0t: out_byte expected none got %h last %b", $time, b, last);
				bad_count++;
				return;
			end
			e = coded_q.pop_front();
			if (e.b !== b) begin
				$display("%0t: out_byte expected %h got %h", $time, e.b, b);
				bad_count++;
			end
			if (e.last !== last) begin
				$display("%0t: last expected %b got %b", $time, e.last, last);
				bad_count++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tuser = 1'b0;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = REG_ESCAPE_FROM;
	logic       cfg_data = 1'b0;

	qp_encoded_bytes sb;
	int              send_pct = 0;
	int              recv_pct = 0;
	int              quiet_cycles = 0;
	int              col = 0;
	int              line_left = 20;
	logic [7:0]      pre_q[$];

	quoted_printable_stream_encoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= (recv_pct == 0) || ($urandom_range(99) >= recv_pct);
	end

	// items in are noted before items out are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.take_raw(s_tuser, s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				sb.match_byte(m_tdata, m_tlast);
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("quoted_printable_stream_encoder: mismatch");
			$finish;
		end
	end

	task automatic send(input bit hb, input logic [7:0] d, input bit eop);
		while (send_pct != 0 && $urandom_range(99) < send_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= hb;
		s_tdata <= d;
		s_tlast <= eop;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input bit v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, v);
	endtask

	task automatic set_config(input bit esc, input bit dot, input bit crlf);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_ESCAPE_FROM, esc);
		write_reg(REG_DOT_STUFFING, dot);
		write_reg(REG_EOL_CRLF, crlf);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send(1'b1, s[i], 1'b0);
	endtask

	task automatic new_line();
		col = 0;
		line_left = ($urandom_range(3) == 0) ? $urandom_range(60, 110) : $urandom_range(0, 40);
	endtask

	function automatic logic [7:0] body_byte();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 8'($urandom_range(8'h21, 8'h7E));
		else if (r < 70)
			return CH_SP;
		else if (r < 77)
			return CH_TAB;
		else if (r < 82)
			return CH_EQ;
		else if (r < 89)
			return 8'($urandom_range(0, 255));
		else if (r < 95)
			return 8'($urandom_range(8'h80, 8'hFF));
		else
			return 8'($urandom_range(0, 8'h1F));
	endfunction

	// mostly lines of text, some starting with From or a period
	task automatic pick_item(output bit hb, output logic [7:0] d, output bit eop);
		int r;
		r = $urandom_range(99);
		hb = (r >= 4);
		eop = (r < 2) || (r >= 96);
		d = 8'($urandom_range(0, 255));
		if (hb) begin
			if (pre_q.size() != 0) begin
				d = pre_q.pop_front();
			end else if (col == 0 && $urandom_range(3) == 0) begin
				if ($urandom_range(1)) begin
					d = FROM_WORD[31:24];
					for (int i = 1; i < 4; i++)
						pre_q.push_back(FROM_WORD[8*(3-i) +: 8]);
					pre_q.push_back(($urandom_range(4) != 0) ? CH_SP : body_byte());
				end else begin
					d = CH_DOT;
				end
			end else if (line_left <= 0) begin
				d = CH_LF;
				if ($urandom_range(3) == 0) begin
					d = $urandom_range(1) ? CH_SP : CH_TAB;
					pre_q.push_back(CH_LF);
				end
			end else begin
				d = body_byte();
			end
			if (d == CH_LF) begin
				new_line();
			end else begin
				col++;
				line_left--;
			end
		end
		if (eop)
			new_line();
	endtask

	task automatic random_phase(input int n, input bit pause_mid);
		bit         hb;
		bit         eop;
		logic [7:0] d;
		int         sent;
		sent = 0;
		while (sent < n) begin
			pick_item(hb, d, eop);
			send(hb, d, eop);
			if (hb || eop)
				sent++;
			if (pause_mid && sent == n / 2) begin
				drain();
				pause_mid = 1'b0;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		set_config(1'b1, 1'b1, 1'b1);
		send_text("From x\n");
		send(1'b1, CH_DOT, 1'b0);
		send(1'b1, CH_TAB, 1'b0);
		send(1'b1, CH_LF, 1'b0);
		send(1'b1, 8'h00, 1'b0);
		send(1'b1, 8'hFF, 1'b0);
		send(1'b1, CH_EQ, 1'b0);
		send(1'b1, CH_DEL, 1'b0);
		send(1'b1, 8'h1F, 1'b0);
		send(1'b1, 8'h7E, 1'b0);
		send(1'b1, CH_SP, 1'b0);
		send(1'b1, CH_LF, 1'b0);
		send(1'b1, 8'h41, 1'b0);
		send(1'b1, CH_SP, 1'b0);
		send(1'b0, 8'h5A, 1'b1);
		send(1'b0, 8'hA5, 1'b0);
		send(1'b1, CH_TAB, 1'b0);
		send(1'b1, 8'h62, 1'b1);
		send(1'b0, 8'h00, 1'b1);

		set_config(1'b0, 1'b0, 1'b0);
		send_pct = 0;
		recv_pct = 0;
		random_phase(80, 1'b0);

		set_config(1'b1, 1'b1, 1'b1);
		send_pct = 78;
		recv_pct = 0;
		random_phase(80, 1'b1);

		set_config(1'b1, 1'b0, 1'b0);
		send_pct = 0;
		recv_pct = 78;
		random_phase(80, 1'b0);

		set_config(1'b0, 1'b1, 1'b1);
		send_pct = 15;
		recv_pct = 15;
		random_phase(80, 1'b0);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.bad_count == 0 && sb.pending() == 0)
			$display("quoted_printable_stream_encoder: match");
		else
			$display("quoted_printable_stream_encoder: mismatch");
		$finish;
	end

endmodule
